### design/base64_stream_decoder_core_macros.svh
// assertion helpers for the decoder back end (b64d_back)
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define B64D_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// trigger implies a consequence in the next cycle
`define B64D_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

### design/b64d_pkg.sv
package b64d_pkg;

	localparam int MAX_CHARS = 4096;
	localparam int CNT_W = 12;
	localparam int RAW_CAP = MAX_CHARS / 4 * 3;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'((RAW_CAP < 4095) ? RAW_CAP : 4095);

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_SEXTET = 2'd0,
		KIND_PAD    = 2'd1,
		KIND_BAD    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK  = 2'd0,
		STATUS_LEN = 2'd1,
		STATUS_BAD = 2'd2
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] sextet;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

### design/b64d_front.sv
module b64d_front (
	input  logic [7:0]      char_in,
	input  logic            last_char,
	output b64d_pkg::entry_t entry
);
	import b64d_pkg::*;

	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5a;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7a;
	localparam logic [7:0] CH_D0 = 8'h30;
	localparam logic [7:0] CH_D9 = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_PAD = 8'h3d;

	logic [7:0] diff;

	always_comb begin
		entry.last = last_char;
		entry.kind = KIND_BAD;
		entry.sextet = '0;
		diff = '0;
		priority if (char_in >= CH_UA && char_in <= CH_UZ) begin
			diff = char_in - CH_UA;
			entry.kind = KIND_SEXTET;
			entry.sextet = diff[5:0];
		end else if (char_in >= CH_LA && char_in <= CH_LZ) begin
			diff = char_in - CH_LA + 8'd26;
			entry.kind = KIND_SEXTET;
			entry.sextet = diff[5:0];
		end else if (char_in >= CH_D0 && char_in <= CH_D9) begin
			diff = char_in - CH_D0 + 8'd52;
			entry.kind = KIND_SEXTET;
			entry.sextet = diff[5:0];
		end else if (char_in == CH_PLUS) begin
			entry.kind = KIND_SEXTET;
			entry.sextet = 6'd62;
		end else if (char_in == CH_SLASH) begin
			entry.kind = KIND_SEXTET;
			entry.sextet = 6'd63;
		end else if (char_in == CH_PAD) begin
			entry.kind = KIND_PAD;
		end else begin
			entry.kind = KIND_BAD;
		end
	end

endmodule

### design/b64d_queue.sv
module b64d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64d_pkg::entry_t wr_entry,
	input  logic             pop,
	output b64d_pkg::entry_t rd_entry,
	output b64d_pkg::qstat_t qstat
);
	import b64d_pkg::*;

	entry_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_entry = mem_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full = (count_q == (QAW+1)'(QDEPTH));

endmodule

### design/b64d_back.sv
module b64d_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  b64d_pkg::entry_t          entry,
	input  b64d_pkg::qstat_t          qstat,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                byte_out,
	output logic                      byte_valid,
	output logic                      done_res,
	output logic [1:0]                status,
	output logic [b64d_pkg::CNT_W-1:0] decoded_count
);
	import b64d_pkg::*;

	`include "base64_stream_decoder_core_macros.svh"

	logic [1:0]       phase_q;
	logic [7:0]       part_q;
	logic [CNT_W-1:0] total_q;
	logic             pad_q;
	logic             bad_q;

	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             byte_valid_q;
	logic             done_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;

	logic             out_ready;
	logic             emit;
	logic             res;
	logic [1:0]       phase_nx;
	logic [7:0]       part_nx;
	logic [7:0]       byte_nx;
	logic [CNT_W-1:0] total_nx;
	logic             pad_nx;
	logic             bad_nx;
	status_t          status_nx;

	assign out_ready = !out_valid_q || !out_stall;
	assign pop = !qstat.empty && out_ready;

	always_comb begin
		emit = 1'b0;
		byte_nx = '0;
		part_nx = part_q;
		pad_nx = pad_q;
		bad_nx = bad_q;
		phase_nx = phase_q + 2'd1;
		// once stopped by pad or a bad char, words are only counted
		if (!pad_q && !bad_q) begin
			unique case (entry.kind)
				KIND_PAD: pad_nx = 1'b1;
				KIND_BAD: bad_nx = 1'b1;
				KIND_SEXTET: begin
					unique case (phase_q)
						2'd0: part_nx = {entry.sextet, 2'b00};
						2'd1: begin
							byte_nx = part_q | {6'b0, entry.sextet[5:4]};
							part_nx = {entry.sextet[3:0], 4'b0};
							emit = 1'b1;
						end
						2'd2: begin
							byte_nx = part_q | {4'b0, entry.sextet[5:2]};
							part_nx = {entry.sextet[1:0], 6'b0};
							emit = 1'b1;
						end
						default: begin
							byte_nx = part_q | {2'b0, entry.sextet};
							part_nx = '0;
							emit = 1'b1;
						end
					endcase
				end
				default: bad_nx = 1'b1;
			endcase
		end
		total_nx = (emit && total_q < COUNT_CAP) ? total_q + 1'b1 : total_q;
		priority if (phase_nx != 2'd0) begin
			status_nx = STATUS_LEN;
		end else if (bad_nx) begin
			status_nx = STATUS_BAD;
		end else begin
			status_nx = STATUS_OK;
		end
		res = emit || entry.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			part_q <= '0;
			total_q <= '0;
			pad_q <= 1'b0;
			bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (entry.last) begin
					phase_q <= '0;
					part_q <= '0;
					total_q <= '0;
					pad_q <= 1'b0;
					bad_q <= 1'b0;
				end else begin
					phase_q <= phase_nx;
					part_q <= part_nx;
					total_q <= total_nx;
					pad_q <= pad_nx;
					bad_q <= bad_nx;
				end
			end
			if (out_ready) begin
				out_valid_q <= pop && res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res) begin
			byte_q <= byte_nx;
			byte_valid_q <= emit;
			done_q <= entry.last;
			status_q <= entry.last ? status_nx : STATUS_OK;
			count_q <= (entry.last && status_nx == STATUS_OK) ? total_nx : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_out = byte_q;
	assign byte_valid = byte_valid_q;
	assign done_res = done_q;
	assign status = status_q;
	assign decoded_count = count_q;

	`B64D_ASSERT(a_pop_nonempty, !(pop && qstat.empty), "pop from empty queue")
	`B64D_ASSERT(a_total_cap, total_q <= COUNT_CAP, "byte total above cap")
	`B64D_ASSERT(a_err_count, !(out_valid_q && status_q != STATUS_OK && count_q != '0),
		"nonzero count with error status")
	`B64D_ASSERT_NEXT(a_last_clears, pop && entry.last,
		phase_q == 2'd0 && !pad_q && !bad_q && total_q == '0,
		"string state not cleared after last word")

endmodule

### design/base64_stream_decoder_core.sv
// streaming base64 decoder, standard alphabet
// input channel: char_in and last_char with in_valid / in_stall; a word is
// taken when in_valid is high and in_stall is low. last_char marks the end
// of a string.
// output channel: byte_out, byte_valid, done_res, status, decoded_count
// with out_valid / out_stall. a result is produced when a byte completes
// or for the last character; other characters give no result.
// on done_res, status is 0 ok, 1 length not a multiple of four, 2 bad
// character, and decoded_count holds the byte count (0 on error). bytes
// already delivered for a failed string are to be dropped by the user.
// path: a taken character is written into the queue; the back end pops it
// when the output register is free and loads the result into that register,
// which drives out_valid.
// throughput: one character per clock while out_stall is low, set by the
// decode step in the back end and the one-entry output register.
// a 4-entry queue sits between classifier and decoder; while out_stall is
// high the queue fills and in_stall rises when it is full.
// reset empties the queue and clears out_valid and the string state.
module base64_stream_decoder_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                char_in,
	input  logic                      last_char,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                byte_out,
	output logic                      byte_valid,
	output logic                      done_res,
	output logic [1:0]                status,
	output logic [b64d_pkg::CNT_W-1:0] decoded_count
);
	import b64d_pkg::*;

	entry_t in_entry;
	entry_t q_entry;
	qstat_t qstat;
	logic   push;
	logic   pop;

	assign in_stall = qstat.full;
	assign push = in_valid && !qstat.full;

	b64d_front u_front (
		.char_in   (char_in),
		.last_char (last_char),
		.entry     (in_entry)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (in_entry),
		.pop      (pop),
		.rd_entry (q_entry),
		.qstat    (qstat)
	);

	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.entry         (q_entry),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_out      (byte_out),
		.byte_valid    (byte_valid),
		.done_res      (done_res),
		.status        (status),
		.decoded_count (decoded_count)
	);

endmodule
